### hdl/wmps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmps_pkg: shared types and constants of the windowed min priority sorter
// Holds the data width, the per-cycle cell command and the controller states.
// ----------------------------------------------------------------------------
package wmps_pkg;

  localparam int unsigned DataW = 32;

  typedef logic signed [DataW-1:0] data_t;

  // Command broadcast to every cell of the chain
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    data_t    key;
  } cell_ctrl_t;

  // Controller states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_POP   = 4'b0010,
    ST_INS   = 4'b0100,
    ST_DRAIN = 4'b1000
  } ctrl_state_e;

endpackage

### hdl/wmps_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmps_if: request and result channels of the sorter
// Valid/ready channels; a request or result moves when both are high.
// ----------------------------------------------------------------------------
interface wmps_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               final_item;

  modport source (output valid, output value, output final_item, input ready);
  modport sink (input valid, input value, input final_item, output ready);
endinterface

interface wmps_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] winner;
  logic               run_end;

  modport source (output valid, output winner, output run_end, input ready);
  modport sink (input valid, input winner, input run_end, output ready);
endinterface

### hdl/wmps_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmps_cell: one slot of the sorted chain
// Holds one value and its valid bit; inserts by shifting right from the left
// neighbor, pops by shifting left from the right neighbor.
// ----------------------------------------------------------------------------
module wmps_cell import wmps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  data_t      left_val_i,
  input  logic       left_vld_i,
  input  logic       left_gt_i,
  input  data_t      right_val_i,
  input  logic       right_vld_i,
  output data_t      val_o,
  output logic       vld_o,
  output logic       gt_o
);

  data_t val_q, val_d;
  logic  vld_q, vld_d;

  // Slot is empty or holds a value greater than the key
  assign gt_o  = !vld_q || (val_q > ctrl_i.key);
  assign val_o = val_q;
  assign vld_o = vld_q;

  // Select next slot content
  always_comb begin
    val_d = val_q;
    vld_d = vld_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        if (gt_o) begin
          if (left_gt_i) begin
            val_d = left_val_i;
            vld_d = left_vld_i;
          end else begin
            val_d = ctrl_i.key;
            vld_d = 1'b1;
          end
        end
      end
      OP_POP: begin
        val_d = right_val_i;
        vld_d = right_vld_i;
      end
      default: begin
        val_d = val_q;
        vld_d = vld_q;
      end
    endcase
  end

  // Hold valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Hold value
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

### hdl/windowed_min_priority_sorter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_min_priority_sorter_unit: replacement-selection sorter
// A chain of QUEUE_DEPTH cells keeps the held values in ascending order.
// ----------------------------------------------------------------------------
// While the chain is not full, a request is inserted in the cycle it is taken
// and the next request may follow in the next cycle. Once the chain holds
// QUEUE_DEPTH values, a request is taken in ST_IDLE, the minimum is popped
// into the result register in ST_POP once that register is empty or taken,
// and the request is inserted in ST_INS; the request port then reopens.
// A request marked final_item then drains the chain, one result per cycle
// while the result side keeps taking, and flags the last result with run_end.
// Pops wait while the result register is full and not taken. The input side
// is taken again while the last result still waits in the result register.
// ----------------------------------------------------------------------------
module windowed_min_priority_sorter_unit import wmps_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wmps_in_if.sink    req_i,
  wmps_out_if.source res_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  ctrl_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  data_t pend_val_q, pend_val_d;
  logic  pend_fin_q, pend_fin_d;
  logic  res_vld_q, res_vld_d;
  data_t res_val_q, res_val_d;
  logic  res_end_q, res_end_d;

  cell_ctrl_t ctrl;
  data_t cell_val [QUEUE_DEPTH];
  logic  cell_vld [QUEUE_DEPTH];
  logic  cell_gt  [QUEUE_DEPTH];

  logic req_acc, slot_free, full, res_load;

  assign req_i.ready   = (state_q == ST_IDLE);
  assign req_acc       = req_i.valid && req_i.ready;
  assign slot_free     = !res_vld_q || res_o.ready;
  assign full          = (cnt_q == CntW'(QUEUE_DEPTH));
  assign res_o.valid   = res_vld_q;
  assign res_o.winner  = res_val_q;
  assign res_o.run_end = res_end_q;

  // Build the cell chain
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    data_t l_val, r_val;
    logic  l_vld, l_gt, r_vld;
    if (i == 0) begin : g_first
      assign l_val = '0;
      assign l_vld = 1'b0;
      assign l_gt  = 1'b0;
    end else begin : g_mid
      assign l_val = cell_val[i-1];
      assign l_vld = cell_vld[i-1];
      assign l_gt  = cell_gt[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign r_val = '0;
      assign r_vld = 1'b0;
    end else begin : g_inner
      assign r_val = cell_val[i+1];
      assign r_vld = cell_vld[i+1];
    end
    wmps_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .left_val_i (l_val),
      .left_vld_i (l_vld),
      .left_gt_i  (l_gt),
      .right_val_i(r_val),
      .right_vld_i(r_vld),
      .val_o      (cell_val[i]),
      .vld_o      (cell_vld[i]),
      .gt_o       (cell_gt[i])
    );
  end

  // Sequence insert, pop and drain
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    pend_val_d = pend_val_q;
    pend_fin_d = pend_fin_q;
    ctrl.op    = OP_HOLD;
    ctrl.key   = pend_val_q;
    res_load   = 1'b0;
    res_end_d  = res_end_q;
    case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          pend_val_d = req_i.value;
          pend_fin_d = req_i.final_item;
          if (full) begin
            state_d = ST_POP;
          end else begin
            ctrl.op  = OP_INSERT;
            ctrl.key = req_i.value;
            cnt_d    = cnt_q + 1'b1;
            state_d  = req_i.final_item ? ST_DRAIN : ST_IDLE;
          end
        end
      end
      ST_POP: begin
        if (slot_free) begin
          ctrl.op   = OP_POP;
          res_load  = 1'b1;
          res_end_d = 1'b0;
          cnt_d     = cnt_q - 1'b1;
          state_d   = ST_INS;
        end
      end
      ST_INS: begin
        ctrl.op = OP_INSERT;
        cnt_d   = cnt_q + 1'b1;
        state_d = pend_fin_q ? ST_DRAIN : ST_IDLE;
      end
      ST_DRAIN: begin
        if (slot_free) begin
          ctrl.op   = OP_POP;
          res_load  = 1'b1;
          res_end_d = (cnt_q == CntW'(1));
          cnt_d     = cnt_q - 1'b1;
          if (cnt_q == CntW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Advance the result register
  always_comb begin
    res_val_d = res_load ? cell_val[0] : res_val_q;
    if (res_load) begin
      res_vld_d = 1'b1;
    end else if (res_o.ready) begin
      res_vld_d = 1'b0;
    end else begin
      res_vld_d = res_vld_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      res_vld_q <= res_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_val_q <= pend_val_d;
    pend_fin_q <= pend_fin_d;
    res_val_q  <= res_val_d;
    res_end_q  <= res_end_d;
  end

  // Count never passes the chain length
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QUEUE_DEPTH))
    else $error("held count exceeds depth");

  // Head cell occupancy tracks the count
  a_head_vld: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_vld[0] == (cnt_q != '0))
    else $error("head cell valid disagrees with count");

  // Pop before insert happens only on a full chain
  a_pop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) |-> full)
    else $error("pop state entered without a full chain");

  // Flagged result leaves the chain empty and idle
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && res_end_d) |=> (cnt_q == '0) && (state_q == ST_IDLE))
    else $error("run end issued with values still held");

endmodule
